// ===== hdl/vumph_pkg.sv =====
// ============================================================================
// VU meter package
// Shared widths, register codes, reset values and the log2 fraction table.
// ============================================================================
package vumph_pkg;

    // Default build parameters
    localparam int LED_COUNT_DEF   = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // Level scale: 60 dB in 1/16 dB steps
    localparam int FULL_LEVEL = 960;
    localparam int LEVEL_W    = 10;

    // Register widths
    localparam int FS_W    = 15;
    localparam int HOLD_W  = 8;
    localparam int DECAY_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Register reset values
    localparam logic [FS_W-1:0]    FS_RESET    = 15'd32767;
    localparam logic [HOLD_W-1:0]  HOLD_RESET  = 8'd30;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 8'd8;

    // LED bar
    localparam int MASK_W     = 32;
    localparam int PLED_OUT_W = 6;
    localparam int PLED_W     = 7;
    localparam int PLED_SHIFT = 20;

    // log2 in Q12
    localparam int LOG_FRAC = 12;
    localparam int TAB_W    = 13;
    localparam int IDX_W    = 4;
    localparam int REM_W    = 8;

    // dB conversion: 320*log10(2) in Q16, product scaled by 2^-28
    localparam int DB_MULT_W   = 24;
    localparam logic signed [DB_MULT_W-1:0] DB_MULT = 24'sd6313057;
    localparam int ROUND_SHIFT = 28;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_SCALE  = 2'd0,
        CFG_HOLD_FRAMES = 2'd1,
        CFG_DECAY_STEP  = 2'd2
    } t_cfg_idx;

    // Load enables for the pipeline ranks after the input rank
    typedef struct packed {
        logic ld_norm;
        logic ld_log;
        logic ld_prod;
        logic ld_level;
        logic ld_peak;
        logic ld_out;
    } t_pipe_en;

    // round(4096*log2(1+k/16)), k = 0..16
    function automatic logic [TAB_W-1:0] log_tab(input logic [IDX_W:0] k);
        logic [TAB_W-1:0] v;
        case (k)
            5'd0:    v = 13'd0;
            5'd1:    v = 13'd358;
            5'd2:    v = 13'd696;
            5'd3:    v = 13'd1016;
            5'd4:    v = 13'd1319;
            5'd5:    v = 13'd1607;
            5'd6:    v = 13'd1882;
            5'd7:    v = 13'd2145;
            5'd8:    v = 13'd2396;
            5'd9:    v = 13'd2637;
            5'd10:   v = 13'd2869;
            5'd11:   v = 13'd3092;
            5'd12:   v = 13'd3307;
            5'd13:   v = 13'd3514;
            5'd14:   v = 13'd3715;
            5'd15:   v = 13'd3908;
            5'd16:   v = 13'd4096;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/vumph_log2.sv =====
// ============================================================================
// vumph_log2
// Two-rank log2 in Q12: leading-one normalise, then table interpolation.
// ============================================================================
module vumph_log2 #(
    parameter int W     = 16,
    parameter int LOG_W = 17
) (
    input  logic                  i_clk,
    input  vumph_pkg::t_pipe_en   i_en,
    input  logic [W-1:0]          i_val,
    output logic [LOG_W-1:0]      o_log
);
    localparam int E_W = (W > 1) ? $clog2(W) : 1;
    localparam int X_W = W + vumph_pkg::LOG_FRAC;

    logic [E_W-1:0]                  e;
    logic [E_W-1:0]                  sa;
    logic [X_W-1:0]                  sh;
    logic [E_W-1:0]                  r_e;
    logic [vumph_pkg::IDX_W-1:0]     r_idx;
    logic [vumph_pkg::REM_W-1:0]     r_rem;
    logic [vumph_pkg::TAB_W-1:0]     lo;
    logic [vumph_pkg::TAB_W-1:0]     hi;
    logic [8:0]                      step;
    logic [16:0]                     prodi;
    logic [16:0]                     rnd;
    logic [LOG_W-1:0]                n_log;
    logic [LOG_W-1:0]                r_log;

    // top set bit, then bring it to the top of the extended word
    always_comb begin
        e = '0;
        for (int i = 0; i < W; i++) begin
            if (i_val[i]) begin
                e = E_W'(i);
            end
        end
        sa = E_W'(W - 1) - e;
        sh = {i_val, {vumph_pkg::LOG_FRAC{1'b0}}} << sa;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_norm) begin
            r_e   <= e;
            r_idx <= sh[X_W-2 -: vumph_pkg::IDX_W];
            r_rem <= sh[X_W-2-vumph_pkg::IDX_W -: vumph_pkg::REM_W];
        end
    end

    // interpolate between neighbouring table entries
    always_comb begin
        lo    = vumph_pkg::log_tab({1'b0, r_idx});
        hi    = vumph_pkg::log_tab({1'b0, r_idx} + 5'd1);
        step  = 9'(hi - lo);
        prodi = 17'(step) * 17'(r_rem);
        rnd   = prodi + 17'd128;
        n_log = LOG_W'({r_e, {vumph_pkg::LOG_FRAC{1'b0}}}) + LOG_W'(lo) + LOG_W'(rnd[16:8]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_log) begin
            r_log <= n_log;
        end
    end

    assign o_log = r_log;

endmodule

// ===== hdl/vumph_level.sv =====
// ============================================================================
// vumph_level
// Log ratio to dB level: scale by the dB constant, round and clamp to 0..960.
// ============================================================================
module vumph_level #(
    parameter int LOG_W = 17
) (
    input  logic                             i_clk,
    input  vumph_pkg::t_pipe_en              i_en,
    input  logic [LOG_W-1:0]                 i_log_max,
    input  logic [LOG_W-1:0]                 i_log_fs,
    input  logic                             i_zero,
    output logic [vumph_pkg::LEVEL_W-1:0]    o_level
);
    localparam int DIFF_W = LOG_W + 1;
    localparam int PROD_W = DIFF_W + vumph_pkg::DB_MULT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - vumph_pkg::ROUND_SHIFT;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (vumph_pkg::ROUND_SHIFT - 1);

    logic signed [DIFF_W-1:0]          diff;
    logic signed [PROD_W-1:0]          r_prod;
    logic [PROD_W-1:0]                 neg;
    logic [SUM_W-1:0]                  sum;
    logic [Q_W-1:0]                    q;
    logic [Q_W-1:0]                    lvl_sub;
    logic [vumph_pkg::LEVEL_W-1:0]     n_level;
    logic [vumph_pkg::LEVEL_W-1:0]     r_level;

    assign diff = signed'({1'b0, i_log_max}) - signed'({1'b0, i_log_fs});

    always_ff @(posedge i_clk) begin
        if (i_en.ld_prod) begin
            r_prod <= PROD_W'(diff) * PROD_W'(vumph_pkg::DB_MULT);
        end
    end

    // a non-negative product always lands at or above full level
    always_comb begin
        neg     = PROD_W'(-r_prod);
        sum     = {1'b0, neg} + HALF;
        q       = sum[SUM_W-1:vumph_pkg::ROUND_SHIFT];
        lvl_sub = Q_W'(vumph_pkg::FULL_LEVEL) - q;
        if (i_zero) begin
            n_level = '0;
        end else if (!r_prod[PROD_W-1]) begin
            n_level = vumph_pkg::LEVEL_W'(vumph_pkg::FULL_LEVEL);
        end else if (q > Q_W'(vumph_pkg::FULL_LEVEL)) begin
            n_level = '0;
        end else begin
            n_level = lvl_sub[vumph_pkg::LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_level) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

// ===== hdl/vumph_peak_hold.sv =====
// ============================================================================
// vumph_peak_hold
// Held peak state: capture, hold for a frame count, then decay per frame.
// ============================================================================
module vumph_peak_hold (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vumph_pkg::t_pipe_en              i_en,
    input  logic                             i_step,
    input  logic [vumph_pkg::LEVEL_W-1:0]    i_level,
    input  logic [vumph_pkg::HOLD_W-1:0]     i_hold_frames,
    input  logic [vumph_pkg::DECAY_W-1:0]    i_decay_step,
    output logic [vumph_pkg::LEVEL_W-1:0]    o_level,
    output logic [vumph_pkg::LEVEL_W-1:0]    o_shown
);
    logic [vumph_pkg::LEVEL_W-1:0] r_peak;
    logic [vumph_pkg::LEVEL_W-1:0] n_peak;
    logic [vumph_pkg::HOLD_W-1:0]  r_hold_left;
    logic [vumph_pkg::HOLD_W-1:0]  n_hold_left;
    logic [vumph_pkg::LEVEL_W-1:0] shown;
    logic [vumph_pkg::HOLD_W-1:0]  hold_eff;
    logic                          capture;
    logic [vumph_pkg::LEVEL_W-1:0] r_level;
    logic [vumph_pkg::LEVEL_W-1:0] r_shown;

    always_comb begin
        capture  = (r_peak <= i_level);
        shown    = capture ? i_level : r_peak;
        hold_eff = capture ? i_hold_frames : r_hold_left;
        if (hold_eff != '0) begin
            n_hold_left = hold_eff - 1'b1;
            n_peak      = shown;
        end else begin
            n_hold_left = '0;
            n_peak      = (shown > vumph_pkg::LEVEL_W'(i_decay_step)) ?
                          shown - vumph_pkg::LEVEL_W'(i_decay_step) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_hold_left <= '0;
        end else if (i_step) begin
            r_peak      <= n_peak;
            r_hold_left <= n_hold_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_peak) begin
            r_level <= i_level;
            r_shown <= shown;
        end
    end

    assign o_level = r_level;
    assign o_shown = r_shown;

endmodule

// ===== hdl/vumph_led_bar.sv =====
// ============================================================================
// vumph_led_bar
// LED bar mask and peak LED index, held in the output register.
// ============================================================================
module vumph_led_bar #(
    parameter int LED_COUNT = vumph_pkg::LED_COUNT_DEF
) (
    input  logic                                i_clk,
    input  vumph_pkg::t_pipe_en                 i_en,
    input  logic [vumph_pkg::LEVEL_W-1:0]       i_level,
    input  logic [vumph_pkg::LEVEL_W-1:0]       i_shown,
    output logic [vumph_pkg::LEVEL_W-1:0]       o_level_db,
    output logic [vumph_pkg::LEVEL_W-1:0]       o_held_peak_db,
    output logic [vumph_pkg::MASK_W-1:0]        o_lit_mask,
    output logic [vumph_pkg::PLED_OUT_W-1:0]    o_peak_led
);
    // shown*LED_COUNT/960 as a multiply by a rounded-up reciprocal
    localparam int PLED_MUL = (LED_COUNT * (2 ** vumph_pkg::PLED_SHIFT) +
                               vumph_pkg::FULL_LEVEL - 1) / vumph_pkg::FULL_LEVEL;
    localparam int PW = vumph_pkg::PLED_SHIFT + vumph_pkg::PLED_W;

    logic [PW-1:0]                      pprod;
    logic [vumph_pkg::PLED_W-1:0]       n_pled;
    logic [vumph_pkg::MASK_W-1:0]       n_mask;
    logic [vumph_pkg::LEVEL_W-1:0]      r_level;
    logic [vumph_pkg::LEVEL_W-1:0]      r_shown;
    logic [vumph_pkg::MASK_W-1:0]       r_mask;
    logic [vumph_pkg::PLED_W-1:0]       r_pled;

    assign pprod  = PW'(i_shown) * PW'(PLED_MUL);
    assign n_pled = pprod[PW-1 -: vumph_pkg::PLED_W];

    for (genvar gi = 0; gi < vumph_pkg::MASK_W; gi++) begin : g_led
        if (gi < LED_COUNT) begin : g_on
            localparam int THR = (vumph_pkg::FULL_LEVEL * gi) / LED_COUNT;
            assign n_mask[gi] = (i_level > vumph_pkg::LEVEL_W'(THR)) ||
                                (n_pled == vumph_pkg::PLED_W'(gi));
        end else begin : g_off
            assign n_mask[gi] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_out) begin
            r_level <= i_level;
            r_shown <= i_shown;
            r_mask  <= n_mask;
            r_pled  <= n_pled;
        end
    end

    assign o_level_db     = r_level;
    assign o_held_peak_db = r_shown;
    assign o_lit_mask     = r_mask;
    assign o_peak_led     = r_pled[vumph_pkg::PLED_OUT_W-1:0];

endmodule

// ===== hdl/vu_meter_peak_hold_unit.sv =====
// ============================================================================
// vu_meter_peak_hold_unit
// VU meter with peak hold: frame maximum, dB level, held peak and LED bar.
// ============================================================================
//
//  Channel   Direction  Handshake           Payload
//  -------   ---------  ------------------  ----------------------------------
//  sample    in         i_valid / o_stall   i_sample, i_last_in_frame
//  result    out        o_valid / i_stall   o_level_db, o_held_peak_db,
//                                           o_lit_mask, o_peak_led, o_frame_max
//  config    in         i_cfg_wr_en         i_cfg_index, i_cfg_data
//
//  One sample beat is taken every cycle while o_stall is low. Only the beat that
//  closes a frame enters the level pipeline; its result reaches the output
//  register after the input rank. The depth is set by the two log2 ranks,
//  the dB multiplier, the round/clamp rank, the peak rank and the LED rank.
//  Reset clears the frame maximum, the held peak and all beat valids; it needs
//  no clearing pass. A stall on the result side holds the output register and
//  backs up through the ranks, stalling the sample side only once every rank
//  holds a beat.
//
module vu_meter_peak_hold_unit #(
    parameter int LED_COUNT   = vumph_pkg::LED_COUNT_DEF,
    parameter int SAMPLE_BITS = vumph_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  logic                                  i_last_in_frame,

    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [vumph_pkg::LEVEL_W-1:0]         o_level_db,
    output logic [vumph_pkg::LEVEL_W-1:0]         o_held_peak_db,
    output logic [vumph_pkg::MASK_W-1:0]          o_lit_mask,
    output logic [vumph_pkg::PLED_OUT_W-1:0]      o_peak_led,
    output logic [SAMPLE_BITS-1:0]                o_frame_max,

    input  logic                                  i_cfg_wr_en,
    input  logic [vumph_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vumph_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    // log2 values reach SAMPLE_BITS*4096 for samples, 15*4096 for full scale
    localparam int SB_E  = $clog2(SAMPLE_BITS);
    localparam int LOG_W = ((SB_E < 4) ? 4 : SB_E) + vumph_pkg::LOG_FRAC;
    localparam int RANKS = 7;

    // configuration registers
    logic [vumph_pkg::FS_W-1:0]     r_full_scale;
    logic [vumph_pkg::HOLD_W-1:0]   r_hold_frames;
    logic [vumph_pkg::DECAY_W-1:0]  r_decay_step;
    logic [vumph_pkg::FS_W-1:0]     fs_eff;

    // pipeline control
    logic [RANKS:1]                 r_vld;
    logic [RANKS+1:1]               rdy;
    logic                           acc;
    logic                           step;
    vumph_pkg::t_pipe_en            en;

    // frame maximum and its copies along the ranks
    logic [SAMPLE_BITS-1:0]         mag;
    logic [SAMPLE_BITS-1:0]         r_run;
    logic [SAMPLE_BITS-1:0]         n_max;
    logic [SAMPLE_BITS-1:0]         r_fmax [1:RANKS];

    logic [LOG_W-1:0]               log_max;
    logic [LOG_W-1:0]               log_fs;
    logic [vumph_pkg::LEVEL_W-1:0]  lvl5;
    logic [vumph_pkg::LEVEL_W-1:0]  lvl6;
    logic [vumph_pkg::LEVEL_W-1:0]  shown6;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale  <= vumph_pkg::FS_RESET;
            r_hold_frames <= vumph_pkg::HOLD_RESET;
            r_decay_step  <= vumph_pkg::DECAY_RESET;
        end else if (i_cfg_wr_en) begin
            case (vumph_pkg::t_cfg_idx'(i_cfg_index))
                vumph_pkg::CFG_FULL_SCALE: begin
                    r_full_scale <= i_cfg_data[vumph_pkg::FS_W-1:0];
                end
                vumph_pkg::CFG_HOLD_FRAMES: begin
                    r_hold_frames <= i_cfg_data[vumph_pkg::HOLD_W-1:0];
                end
                vumph_pkg::CFG_DECAY_STEP: begin
                    r_decay_step <= i_cfg_data[vumph_pkg::DECAY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // a zero full scale counts as one
    assign fs_eff = (r_full_scale == '0) ? vumph_pkg::FS_W'(1) : r_full_scale;

    // ------------------------------------------------------------------
    // Handshake: a rank loads when it is empty or its beat moves on
    // ------------------------------------------------------------------
    always_comb begin
        rdy[RANKS+1] = !i_stall;
        for (int k = RANKS; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign acc     = i_valid && rdy[1];
    assign o_stall = !rdy[1];
    assign step    = rdy[6] && r_vld[5];

    assign en.ld_norm  = rdy[2];
    assign en.ld_log   = rdy[3];
    assign en.ld_prod  = rdy[4];
    assign en.ld_level = rdy[5];
    assign en.ld_peak  = rdy[6];
    assign en.ld_out   = rdy[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= acc && i_last_in_frame;
            end
            for (int k = 2; k <= RANKS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-sample magnitude and running frame maximum
    // ------------------------------------------------------------------
    // the most negative sample wraps to 2^(SAMPLE_BITS-1), read unsigned
    assign mag   = i_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~i_sample + 1'b1)
                                           : SAMPLE_BITS'(i_sample);
    assign n_max = (mag > r_run) ? mag : r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (acc) begin
            r_run <= i_last_in_frame ? '0 : n_max;
        end
    end

    // carry the frame maximum alongside its beat
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_fmax[1] <= n_max;
        end
        for (int k = 2; k <= RANKS; k++) begin
            if (rdy[k]) begin
                r_fmax[k] <= r_fmax[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Level pipeline
    // ------------------------------------------------------------------
    vumph_log2 #(
        .W     (SAMPLE_BITS),
        .LOG_W (LOG_W)
    ) u_log_max (
        .i_clk (i_clk),
        .i_en  (en),
        .i_val (r_fmax[1]),
        .o_log (log_max)
    );

    vumph_log2 #(
        .W     (vumph_pkg::FS_W),
        .LOG_W (LOG_W)
    ) u_log_fs (
        .i_clk (i_clk),
        .i_en  (en),
        .i_val (fs_eff),
        .o_log (log_fs)
    );

    vumph_level #(
        .LOG_W (LOG_W)
    ) u_level (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_log_max (log_max),
        .i_log_fs  (log_fs),
        .i_zero    (r_fmax[4] == '0),
        .o_level   (lvl5)
    );

    // hold the peak; it advances once per frame beat
    vumph_peak_hold u_peak (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_step        (step),
        .i_level       (lvl5),
        .i_hold_frames (r_hold_frames),
        .i_decay_step  (r_decay_step),
        .o_level       (lvl6),
        .o_shown       (shown6)
    );

    vumph_led_bar #(
        .LED_COUNT (LED_COUNT)
    ) u_led (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_level        (lvl6),
        .i_shown        (shown6),
        .o_level_db     (o_level_db),
        .o_held_peak_db (o_held_peak_db),
        .o_lit_mask     (o_lit_mask),
        .o_peak_led     (o_peak_led)
    );

    assign o_valid     = r_vld[RANKS];
    assign o_frame_max = r_fmax[RANKS];

endmodule
